FILE: sv/pvd_pkg.sv
// ---------------------------------------------------------------------------
// pvd_pkg
// Shared types and constants of the probability vector deviation block.
// ---------------------------------------------------------------------------
package pvd_pkg;

	// Fixed field widths
	localparam int CNT_W        = 7;   // outcome count register
	localparam int IDX_PORT_W   = 6;   // index fields on the ports
	localparam int MIN_OUTCOMES = 2;
	localparam int RESET_COUNT  = 2;

	// Input beat kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_REQ  = 1'b1;

	// Sequencer states
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_BAD   = 10'b00_0000_0010,
		S_RDJ   = 10'b00_0000_0100,
		S_CLAMP = 10'b00_0000_1000,
		S_DIVR  = 10'b00_0001_0000,
		S_SUM   = 10'b00_0010_0000,
		S_P2RD  = 10'b00_0100_0000,
		S_P2V   = 10'b00_1000_0000,
		S_P2DIV = 10'b01_0000_0000,
		S_P2OUT = 10'b10_0000_0000
	} pvd_state_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} pvd_div_stat_t;

endpackage

FILE: sv/pvd_ram.sv
// ---------------------------------------------------------------------------
// pvd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module pvd_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/pvd_div.sv
// ---------------------------------------------------------------------------
// pvd_div
// Restoring divider, one quotient bit per cycle. The dividend is
// left-aligned in num and iters of its bits are consumed; rem_init seeds
// the partial remainder and must be below den.
// ---------------------------------------------------------------------------
module pvd_div #(
	parameter int NUM_W = 18,
	parameter int DEN_W = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_W-1:0]             num,
	input  logic [DEN_W-1:0]             rem_init,
	input  logic [DEN_W-1:0]             den,
	input  logic [$clog2(NUM_W+1)-1:0]   iters,
	output logic [NUM_W-1:0]             quo,
	output pvd_pkg::pvd_div_stat_t       stat
);

	localparam int ITER_W = $clog2(NUM_W+1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;

	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    diff;
	logic              q_bit;
	logic [DEN_W-1:0]  rem_next;

	// One trial subtraction per cycle
	always_comb begin
		shifted  = {rem_q, num_q[NUM_W-1]};
		diff     = shifted - {1'b0, den_q};
		q_bit    = ~diff[DEN_W];
		rem_next = q_bit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - ITER_W'(1);
			if (cnt_q == ITER_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			den_q <= den;
			num_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], q_bit};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: sv/probability_vector_deviation.sv
// ---------------------------------------------------------------------------
// probability_vector_deviation
// Stores a probability vector and emits a budget-limited deviation of it.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): a beat with kind = load writes
//   prob_value into the vector store at element_index.
//   A beat with kind = request names target_index and budget; the block
//   then streams outcome_count result beats on the output channel
//   (out_valid/out_ready), index order, is_last on the final one.
//   A target at or above outcome_count gives one beat with bad_request set.
//   Config: outcome_count is written through cfg_wr_en/cfg_wr_data; the user
//   must write it only while idle, which the block does not enforce. It is
//   used limited to 2..MAX_OUTCOMES.
// Processing: a request runs two passes over the store, which has a single
//   read port, plus one shared bit-serial divider for the spread; when the
//   vector sum exceeds one every entry is rescaled through that divider.
//   A new beat is taken only once all results of a request are queued.
// Reset: sequencer idle, output empty, outcome_count = 2; the store holds
//   nothing valid until loaded. A stalled receiver holds the output register
//   and the sequencer waits on it; no beat is dropped.
// ---------------------------------------------------------------------------
module probability_vector_deviation #(
	parameter int MAX_OUTCOMES = 64,
	parameter int FRAC_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pvd_pkg::CNT_W-1:0]         cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [pvd_pkg::IDX_PORT_W-1:0]    element_index,
	input  logic [FRAC_BITS:0]                prob_value,
	input  logic [pvd_pkg::IDX_PORT_W-1:0]    target_index,
	input  logic signed [FRAC_BITS+2:0]       budget,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pvd_pkg::IDX_PORT_W-1:0]    out_index,
	output logic [FRAC_BITS:0]                out_value,
	output logic                              is_last,
	output logic                              bad_request
);

	localparam int CW     = pvd_pkg::CNT_W;
	localparam int PW     = pvd_pkg::IDX_PORT_W;
	localparam int IDX_W  = $clog2(MAX_OUTCOMES);
	localparam int VAL_W  = FRAC_BITS + 1;
	localparam int BUD_W  = FRAC_BITS + 3;
	localparam int Q_W    = FRAC_BITS + 2;
	localparam int SUM_W  = Q_W + IDX_W;
	localparam int ITER_W = $clog2(Q_W + 1);

	localparam logic [CW-1:0]           CNT_MAX  = CW'(MAX_OUTCOMES);
	localparam logic [CW-1:0]           CNT_MIN  = CW'(pvd_pkg::MIN_OUTCOMES);
	localparam logic [SUM_W-1:0]        ONE_SUM  = SUM_W'(1) << FRAC_BITS;
	localparam logic signed [BUD_W-1:0] ONE_B    = BUD_W'(1) << FRAC_BITS;
	localparam logic signed [BUD_W-1:0] LSB_B    = BUD_W'(1);

	pvd_pkg::pvd_state_t state_q, state_d;

	// Control registers
	logic [CW-1:0]      cnt_cfg_q;
	logic               out_valid_q;
	logic               rv_s1;

	// Request registers
	logic [PW-1:0]             tj_q;
	logic signed [BUD_W-1:0]   c_q;
	logic [CW-1:0]             n_q;
	logic signed [BUD_W-1:0]   d_q;
	logic signed [BUD_W-1:0]   rest_q;
	logic [SUM_W-1:0]          s_q;
	logic [CW-1:0]             a_q;
	logic [IDX_W-1:0]          ri_s1;
	logic [IDX_W-1:0]          k_q;
	logic [Q_W-1:0]            q_s2;

	// Output register
	logic [PW-1:0]    out_index_q;
	logic [VAL_W-1:0] out_value_q;
	logic             is_last_q;
	logic             bad_q;

	// Store port
	logic             st_we;
	logic             st_re;
	logic [IDX_W-1:0] st_raddr;
	logic [VAL_W-1:0] st_rdata;

	// Divider port
	logic                   div_start;
	logic [Q_W-1:0]         div_num;
	logic [SUM_W-1:0]       div_rem;
	logic [SUM_W-1:0]       div_den;
	logic [ITER_W-1:0]      div_iters;
	logic [Q_W-1:0]         div_quo;
	pvd_pkg::pvd_div_stat_t dstat;

	// Misc combinational
	logic                    accept;
	logic                    out_free;
	logic                    out_load;
	logic [CW-1:0]           n_eff;
	logic                    req_bad;
	logic [CW-1:0]           n_last;
	logic                    k_is_last;
	logic                    ri_is_last;
	logic                    sum_ren;
	logic                    scale;
	logic                    is_clamp;
	logic                    div_fin;
	logic signed [BUD_W-1:0] c_adj, half, p_ext, lim_hi, lim_lo, d_new;
	logic                    d_new_neg;
	logic [Q_W-1:0]          d_mag;
	logic signed [BUD_W-1:0] quo_s, rest_new;
	logic [IDX_W-1:0]        v_idx;
	logic signed [BUD_W-1:0] shift, v_sum;
	logic [Q_W-1:0]          v_clamp;

	// Handshake
	assign in_ready = (state_q == pvd_pkg::S_IDLE) && !dstat.busy;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Outcome count limited to the supported range
	always_comb begin
		if (cnt_cfg_q < CNT_MIN) begin
			n_eff = CNT_MIN;
		end else if (cnt_cfg_q > CNT_MAX) begin
			n_eff = CNT_MAX;
		end else begin
			n_eff = cnt_cfg_q;
		end
	end

	assign req_bad    = CW'(target_index) >= n_eff;
	assign n_last     = n_q - CW'(1);
	assign k_is_last  = CW'(k_q) == n_last;
	assign ri_is_last = CW'(ri_s1) == n_last;
	assign is_clamp   = state_q == pvd_pkg::S_CLAMP;
	assign sum_ren    = (state_q == pvd_pkg::S_SUM) && (a_q < n_q);
	assign scale      = s_q > ONE_SUM;
	assign div_fin    = dstat.done;

	// Store access: loads while idle, reads by the sequencer
	assign st_we = accept && (kind == pvd_pkg::KIND_LOAD) && (CW'(element_index) < CNT_MAX);

	always_comb begin
		st_re    = 1'b0;
		st_raddr = k_q;
		case (state_q)
			pvd_pkg::S_RDJ: begin
				st_re    = 1'b1;
				st_raddr = tj_q[IDX_W-1:0];
			end
			pvd_pkg::S_SUM: begin
				st_re    = sum_ren;
				st_raddr = a_q[IDX_W-1:0];
			end
			pvd_pkg::S_P2RD: begin
				st_re    = 1'b1;
				st_raddr = k_q;
			end
			default: begin
				st_re    = 1'b0;
				st_raddr = k_q;
			end
		endcase
	end

	pvd_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_OUTCOMES)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (element_index[IDX_W-1:0]),
		.wdata (prob_value),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// Target shift: half the budget toward zero, then limited by p_j
	always_comb begin
		c_adj  = c_q[BUD_W-1] ? c_q + LSB_B : c_q;
		half   = c_adj >>> 1;
		p_ext  = $signed(BUD_W'(st_rdata));
		lim_hi = ONE_B - p_ext;
		lim_lo = -p_ext;
		if (c_q > 0) begin
			d_new = (lim_hi < half) ? lim_hi : half;
		end else begin
			d_new = (lim_lo > half) ? lim_lo : half;
		end
		d_new_neg = d_new[BUD_W-1];
		d_mag     = d_new_neg ? Q_W'(-d_new) : Q_W'(d_new);
	end

	// Spread for the other entries: -d / (n-1), toward zero
	always_comb begin
		quo_s    = $signed(BUD_W'(div_quo));
		rest_new = d_q[BUD_W-1] ? quo_s : -quo_s;
	end

	// Adjusted entry, clipped at zero
	always_comb begin
		v_idx   = (state_q == pvd_pkg::S_SUM) ? ri_s1 : k_q;
		shift   = (v_idx == tj_q[IDX_W-1:0]) ? d_q : rest_q;
		v_sum   = p_ext + shift;
		v_clamp = v_sum[BUD_W-1] ? '0 : v_sum[Q_W-1:0];
	end

	// Divider operands: spread in S_CLAMP, rescale q*ONE/s in S_P2V
	always_comb begin
		div_start = is_clamp || ((state_q == pvd_pkg::S_P2V) && scale);
		if (is_clamp) begin
			div_num   = d_mag;
			div_rem   = '0;
			div_den   = SUM_W'(n_last);
			div_iters = ITER_W'(Q_W);
		end else begin
			div_num   = {v_clamp[0], {(Q_W-1){1'b0}}};
			div_rem   = SUM_W'(v_clamp[Q_W-1:1]);
			div_den   = s_q;
			div_iters = ITER_W'(FRAC_BITS + 1);
		end
	end

	pvd_div #(
		.NUM_W (Q_W),
		.DEN_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.rem_init (div_rem),
		.den      (div_den),
		.iters    (div_iters),
		.quo      (div_quo),
		.stat     (dstat)
	);

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pvd_pkg::S_IDLE: begin
				if (accept && (kind == pvd_pkg::KIND_REQ)) begin
					state_d = req_bad ? pvd_pkg::S_BAD : pvd_pkg::S_RDJ;
				end
			end
			pvd_pkg::S_BAD: begin
				if (out_free) state_d = pvd_pkg::S_IDLE;
			end
			pvd_pkg::S_RDJ:   state_d = pvd_pkg::S_CLAMP;
			pvd_pkg::S_CLAMP: state_d = pvd_pkg::S_DIVR;
			pvd_pkg::S_DIVR: begin
				if (div_fin) state_d = pvd_pkg::S_SUM;
			end
			pvd_pkg::S_SUM: begin
				if (rv_s1 && ri_is_last) state_d = pvd_pkg::S_P2RD;
			end
			pvd_pkg::S_P2RD:  state_d = pvd_pkg::S_P2V;
			pvd_pkg::S_P2V: begin
				state_d = scale ? pvd_pkg::S_P2DIV : pvd_pkg::S_P2OUT;
			end
			pvd_pkg::S_P2DIV: begin
				if (div_fin) state_d = pvd_pkg::S_P2OUT;
			end
			pvd_pkg::S_P2OUT: begin
				if (out_free) state_d = k_is_last ? pvd_pkg::S_IDLE : pvd_pkg::S_P2RD;
			end
			default: state_d = pvd_pkg::S_IDLE;
		endcase
	end

	assign out_load = out_free
		&& ((state_q == pvd_pkg::S_BAD) || (state_q == pvd_pkg::S_P2OUT));

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pvd_pkg::S_IDLE;
			cnt_cfg_q   <= CW'(pvd_pkg::RESET_COUNT);
			out_valid_q <= 1'b0;
			rv_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= sum_ren;
			if (cfg_wr_en) cnt_cfg_q <= cfg_wr_data;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			tj_q <= target_index;
			c_q  <= budget;
			n_q  <= n_eff;
		end
		if (is_clamp) d_q <= d_new;
		if ((state_q == pvd_pkg::S_DIVR) && div_fin) begin
			rest_q <= rest_new;
			a_q    <= '0;
			s_q    <= '0;
			k_q    <= '0;
		end
		// first pass: read every entry and accumulate the clipped sum
		if (sum_ren) a_q <= a_q + CW'(1);
		ri_s1 <= a_q[IDX_W-1:0];
		if (rv_s1 && (state_q == pvd_pkg::S_SUM)) s_q <= s_q + SUM_W'(v_clamp);
		// second pass: recompute each entry, rescale if needed
		if (state_q == pvd_pkg::S_P2V) q_s2 <= v_clamp;
		if ((state_q == pvd_pkg::S_P2DIV) && div_fin) begin
			q_s2 <= {1'b0, div_quo[FRAC_BITS:0]};
		end
		if ((state_q == pvd_pkg::S_P2OUT) && out_free) k_q <= k_q + IDX_W'(1);
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == pvd_pkg::S_BAD) begin
				out_index_q <= tj_q;
				out_value_q <= '0;
				is_last_q   <= 1'b1;
				bad_q       <= 1'b1;
			end else begin
				out_index_q <= PW'(k_q);
				out_value_q <= q_s2[VAL_W-1:0];
				is_last_q   <= k_is_last;
				bad_q       <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_index   = out_index_q;
	assign out_value   = out_value_q;
	assign is_last     = is_last_q;
	assign bad_request = bad_q;

endmodule

FILE: sv/pvd_checker.sv
// ---------------------------------------------------------------------------
// pvd_checker
// Port-level checks of the probability vector deviation block.
// ---------------------------------------------------------------------------
module pvd_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_wr_en,
	input logic [pvd_pkg::CNT_W-1:0]         cfg_wr_data,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              kind,
	input logic [pvd_pkg::IDX_PORT_W-1:0]    element_index,
	input logic [FRAC_BITS:0]                prob_value,
	input logic [pvd_pkg::IDX_PORT_W-1:0]    target_index,
	input logic signed [FRAC_BITS+2:0]       budget,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [pvd_pkg::IDX_PORT_W-1:0]    out_index,
	input logic [FRAC_BITS:0]                out_value,
	input logic                              is_last,
	input logic                              bad_request
);

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index)
			&& $stable(out_value) && $stable(is_last) && $stable(bad_request))
		else $error("output beat changed while stalled");

	// Bad target beat is a lone zero result
	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_request |-> is_last && (out_value == '0))
		else $error("bad request beat malformed");

	// Request makes the block busy
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == pvd_pkg::KIND_REQ) |=> !in_ready)
		else $error("input taken right after a request");

	// Mid-stream result means the request is still running
	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> !in_ready)
		else $error("input open before the final beat was queued");

endmodule

bind probability_vector_deviation pvd_checker #(.FRAC_BITS(FRAC_BITS)) u_pvd_checker (.*);
